// File: design/glyph_quad_text_layout_defines.svh
// ----------------------------------------------------------------------------
// glyph_quad_text_layout_defines.svh
// Assertion macros used by the glyph quad layout top level.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GQTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define GQTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gqtl_pkg.sv
// ----------------------------------------------------------------------------
// gqtl_pkg
// Types, constants and helper functions of the glyph quad layout block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gqtl_pkg;

    // Fixed field widths
    localparam int TEXP_W      = 13;               // texel coordinate incl. width
    localparam int FRAC_W      = 16;               // texcoord fraction bits
    localparam int TC_W        = FRAC_W + 1;       // unsigned 1.16
    localparam int QUO_W       = TC_W + 1;         // quotient bits before clamp
    localparam int NUM_W       = TEXP_W + 1 + FRAC_W;
    localparam int SPACING_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int VTX_PER_GLYPH = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_SPACING = 2'd2;

    localparam logic [CFG_DATA_W-1:0] TEX_SIZE_RESET = 13'd256;
    localparam logic [SPACING_W-1:0]  SPACING_RESET  = 4'd3;

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LAYOUT = 1'b1;

    // Quad corners: bit 0 right edge, bit 1 bottom edge
    localparam logic [1:0] CORNER_TL = 2'b00;
    localparam logic [1:0] CORNER_TR = 2'b01;
    localparam logic [1:0] CORNER_BL = 2'b10;
    localparam logic [1:0] CORNER_BR = 2'b11;

    typedef struct packed {
        logic              operation;
        logic [7:0]        char_code;
        logic [11:0]       glyph_x;
        logic [11:0]       glyph_y;
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic signed [7:0] glyph_xoffset;
        logic signed [7:0] glyph_yoffset;
        logic signed [7:0] glyph_advance;
        logic              first_of_string;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [TC_W-1:0]    tex_u;
        logic [TC_W-1:0]    tex_v;
        logic               glyph_found;
        logic               last_vertex;
    } out_item_t;

    typedef struct packed {
        logic [11:0]       gx;
        logic [11:0]       gy;
        logic [7:0]        gw;
        logic [7:0]        gh;
        logic signed [7:0] xo;
        logic signed [7:0] yo;
        logic signed [7:0] adv;
    } glyph_rec_t;

    typedef struct packed {
        logic               found;
        glyph_rec_t         rec;
        logic               first;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_push_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_LEFT,
        BK_DIV_RIGHT,
        BK_EMIT
    } back_state_t;

    // Other ASCII case of a letter, the code itself otherwise
    function automatic logic [7:0] alt_case(input logic [7:0] code);
        logic [7:0] res;
        begin
            res = code;
            if (code >= 8'h61 && code <= 8'h7a)
            begin
                res = code - 8'd32;
            end
            else if (code >= 8'h41 && code <= 8'h5a)
            begin
                res = code + 8'd32;
            end
            return res;
        end
    endfunction

    // Clamp to 16-bit signed
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        begin
            if (v > 18'sd32767)
            begin
                res = 16'sh7fff;
            end
            else if (v < -18'sd32768)
            begin
                res = -16'sh8000;
            end
            else
            begin
                res = v[15:0];
            end
            return res;
        end
    endfunction

    // Corner of each vertex: two triangles BL BR TL, BR TL TR
    function automatic logic [1:0] corner_sel(input logic [2:0] vtx);
        logic [1:0] res;
        begin
            case (vtx)
                3'd0:    res = CORNER_BL;
                3'd1:    res = CORNER_BR;
                3'd2:    res = CORNER_TL;
                3'd3:    res = CORNER_BR;
                3'd4:    res = CORNER_TL;
                3'd5:    res = CORNER_TR;
                default: res = CORNER_TL;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/gqtl_fifo.sv
// ----------------------------------------------------------------------------
// gqtl_fifo
// Short job queue between the lookup front and the vertex back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqtl_fifo import gqtl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_push_t       push,
    input  logic              pop,
    output job_t              head,
    output logic              head_valid,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    job_t               q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_mem[wr_ptr_reg] <= push.job;
        end
    end

    assign head       = q_mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

`default_nettype wire

// File: design/gqtl_div.sv
// ----------------------------------------------------------------------------
// gqtl_div
// Texel-center texcoord: ((2p+1)*2^16 + S) / (2S), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqtl_div import gqtl_pkg::*;
#(
    parameter int SIZE_W = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TEXP_W-1:0] p,
    input  logic [SIZE_W-1:0] size,
    output logic              done,
    output logic [TC_W-1:0]   q
);

    localparam int DEN_W  = SIZE_W + 1;
    localparam int REM_W  = SIZE_W + 2;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int CMP_W  = (REM_W > HI_W) ? REM_W : HI_W;
    localparam int STEP_W = $clog2(QUO_W);

    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [CMP_W-1:0]  num_hi, den_ext;
    logic              over;

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              over_reg;

    logic [REM_W-1:0]  shifted, rem_new;
    logic              ge;

    // Operands; quotient would not fit in QUO_W bits when num/2^QUO_W >= den
    assign num     = {p, 1'b1, {FRAC_W{1'b0}}} + NUM_W'(size);
    assign den     = {size, 1'b0};
    assign num_hi  = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_ext = CMP_W'(den);
    assign over    = (num_hi >= den_ext);

    // Restoring step
    assign shifted = {rem_reg[REM_W-2:0], low_reg[QUO_W-1]};
    assign ge      = (shifted >= REM_W'(den_reg));
    assign rem_new = ge ? (shifted - REM_W'(den_reg)) : shifted;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_hi[REM_W-1:0];
            low_reg  <= num[QUO_W-1:0];
            den_reg  <= den;
            over_reg <= over;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = (over_reg || quo_reg[QUO_W-1]) ? '1 : quo_reg[TC_W-1:0];

endmodule

`default_nettype wire

// File: design/gqtl_front.sv
// ----------------------------------------------------------------------------
// gqtl_front
// Accepts items, writes glyph loads, resolves lookups and reads the record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqtl_front import gqtl_pkg::*;
#(
    parameter int GLYPH_CODES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output queue_push_t       push,
    input  logic [QCNT_W-1:0] q_count
);

    localparam int CODE_W = $clog2(GLYPH_CODES);
    localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_CODES);

    logic [GLYPH_CODES-1:0] valid_reg;
    glyph_rec_t             rec_mem [GLYPH_CODES];
    glyph_rec_t             rd_rec_reg;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_found_reg;
    logic                   pend_first_reg;
    logic signed [15:0]     pend_sx_reg, pend_sy_reg;

    logic [QCNT_W:0]        occupancy;
    logic                   accept, is_load, is_layout, load_ok;
    logic [7:0]             alt_code;
    logic                   code_ok, alt_ok, code_hit, alt_hit, found;
    logic [CODE_W-1:0]      sel;
    glyph_rec_t             rec_in;

    // Room for the pending read plus one more layout item
    assign occupancy = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(pend_valid_reg);
    assign in_stall  = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign is_load   = accept && (in_data.operation == OP_LOAD);
    assign is_layout = accept && (in_data.operation == OP_LAYOUT);

    // Lookup with case fallback
    assign alt_code = alt_case(in_data.char_code);
    assign code_ok  = ({1'b0, in_data.char_code} < CODE_LIMIT);
    assign alt_ok   = ({1'b0, alt_code} < CODE_LIMIT);
    assign code_hit = code_ok && valid_reg[in_data.char_code[CODE_W-1:0]];
    assign alt_hit  = alt_ok && valid_reg[alt_code[CODE_W-1:0]];
    assign found    = code_hit || alt_hit;
    assign sel      = code_hit ? in_data.char_code[CODE_W-1:0] : alt_code[CODE_W-1:0];
    assign load_ok  = is_load && code_ok;

    assign rec_in.gx  = in_data.glyph_x;
    assign rec_in.gy  = in_data.glyph_y;
    assign rec_in.gw  = in_data.glyph_width;
    assign rec_in.gh  = in_data.glyph_height;
    assign rec_in.xo  = in_data.glyph_xoffset;
    assign rec_in.yo  = in_data.glyph_yoffset;
    assign rec_in.adv = in_data.glyph_advance;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_ok)
        begin
            valid_reg[in_data.char_code[CODE_W-1:0]] <= 1'b1;
        end
    end

    // Glyph record memory, registered read
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            rec_mem[in_data.char_code[CODE_W-1:0]] <= rec_in;
        end
        if (is_layout)
        begin
            rd_rec_reg <= rec_mem[sel];
        end
    end

    // Pending layout item waiting for its record
    assign pend_valid_next = is_layout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_layout)
        begin
            pend_found_reg <= found;
            pend_first_reg <= in_data.first_of_string;
            pend_sx_reg    <= in_data.start_x;
            pend_sy_reg    <= in_data.start_y;
        end
    end

    assign push.valid       = pend_valid_reg;
    assign push.job.found   = pend_found_reg;
    assign push.job.rec     = rd_rec_reg;
    assign push.job.first   = pend_first_reg;
    assign push.job.start_x = pend_sx_reg;
    assign push.job.start_y = pend_sy_reg;

endmodule

`default_nettype wire

// File: design/gqtl_back.sv
// ----------------------------------------------------------------------------
// gqtl_back
// Runs texcoord divisions, walks the six vertices and advances the pen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqtl_back import gqtl_pkg::*;
#(
    parameter int SIZE_W = 13
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  job_t                 head,
    output logic                 pop,
    input  logic [SIZE_W-1:0]    size_u,
    input  logic [SIZE_W-1:0]    size_v,
    input  logic [SPACING_W-1:0] spacing,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    localparam logic [2:0] LAST_VTX = 3'(VTX_PER_GLYPH - 1);

    back_state_t        state_reg, state_next;
    job_t               job_reg;
    logic signed [15:0] pen_x_reg, pen_y_reg;
    logic signed [15:0] pen_x_next;
    logic [TC_W-1:0]    tu0_reg, tu1_reg, tv0_reg, tv1_reg;
    logic [2:0]         vtx_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg;

    logic               div_start, div_done, du_done, dv_done;
    logic [TEXP_W-1:0]  div_pu, div_pv, right_u, right_v;
    logic [TC_W-1:0]    du_q, dv_q;
    logic               out_free, emit, is_last;
    out_item_t          vtx_item;
    logic [1:0]         corner;
    logic signed [17:0] sum_x, sum_y, pen_sum;

    assign div_done = du_done && dv_done;
    assign out_free = !out_valid_reg || !out_stall;
    assign is_last  = (vtx_reg == LAST_VTX);
    assign right_u  = TEXP_W'(job_reg.rec.gx) + TEXP_W'(job_reg.rec.gw);
    assign right_v  = TEXP_W'(job_reg.rec.gy) + TEXP_W'(job_reg.rec.gh);

    // Horizontal and vertical dividers run side by side
    gqtl_div #(.SIZE_W(SIZE_W)) u_div_u
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .p     (div_pu),
        .size  (size_u),
        .done  (du_done),
        .q     (du_q)
    );

    gqtl_div #(.SIZE_W(SIZE_W)) u_div_v
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .p     (div_pv),
        .size  (size_v),
        .done  (dv_done),
        .q     (dv_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = head.found ? BK_DIV_LEFT : BK_EMIT;
                end
            end
            BK_DIV_LEFT:
            begin
                if (div_done)
                begin
                    state_next = BK_DIV_RIGHT;
                end
            end
            BK_DIV_RIGHT:
            begin
                if (div_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_pu    = TEXP_W'(head.rec.gx);
        div_pv    = TEXP_W'(head.rec.gy);
        emit      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop       = head_valid;
                div_start = head_valid && head.found;
            end
            BK_DIV_LEFT:
            begin
                div_start = div_done;
                div_pu    = right_u;
                div_pv    = right_v;
            end
            BK_DIV_RIGHT:
            begin
                div_start = 1'b0;
            end
            BK_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Vertex of the current corner
    always_comb
    begin
        corner = corner_sel(vtx_reg);
        sum_x  = 18'(pen_x_reg) + 18'(job_reg.rec.xo)
               + (corner[0] ? {10'd0, job_reg.rec.gw} : 18'd0);
        sum_y  = 18'(pen_y_reg) + 18'(job_reg.rec.yo)
               + (corner[1] ? {10'd0, job_reg.rec.gh} : 18'd0);
        vtx_item.last_vertex = is_last;
        if (job_reg.found)
        begin
            vtx_item.pos_x       = sat16(sum_x);
            vtx_item.pos_y       = sat16(sum_y);
            vtx_item.tex_u       = corner[0] ? tu1_reg : tu0_reg;
            vtx_item.tex_v       = corner[1] ? tv1_reg : tv0_reg;
            vtx_item.glyph_found = 1'b1;
        end
        else
        begin
            vtx_item.pos_x       = '0;
            vtx_item.pos_y       = '0;
            vtx_item.tex_u       = '0;
            vtx_item.tex_v       = '0;
            vtx_item.glyph_found = 1'b0;
        end
    end

    // Pen advance: advance - 2*xoffset + spacing
    assign pen_sum = 18'(pen_x_reg) + 18'(job_reg.rec.adv) - 18'(job_reg.rec.xo)
                   - 18'(job_reg.rec.xo) + 18'(spacing);
    assign pen_x_next = sat16(pen_sum);

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    // Control registers and pen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            vtx_reg       <= '0;
            out_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                vtx_reg <= '0;
            end
            else if (emit)
            begin
                vtx_reg <= is_last ? 3'd0 : vtx_reg + 3'd1;
            end
            if (pop && head.first)
            begin
                pen_x_reg <= head.start_x;
                pen_y_reg <= head.start_y;
            end
            else if (emit && is_last && job_reg.found)
            begin
                pen_x_reg <= pen_x_next;
            end
        end
    end

    // Job, texcoords and output item
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == BK_DIV_LEFT && div_done)
        begin
            tu0_reg <= du_q;
            tv0_reg <= dv_q;
        end
        if (state_reg == BK_DIV_RIGHT && div_done)
        begin
            tu1_reg <= du_q;
            tv1_reg <= dv_q;
        end
        if (emit)
        begin
            out_item_reg <= vtx_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

// File: design/glyph_quad_text_layout.sv
// ----------------------------------------------------------------------------
// glyph_quad_text_layout
// Glyph table plus text layout: one character becomes six textured vertices.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry load and layout items; an item is taken
//   on a clock edge with in_valid high and in_stall low. A load gives no result.
//   A layout item gives six vertex items on out_valid/out_stall/out_data,
//   the last one flagged by last_vertex.
//   The cfg channel (cfg_valid/cfg_ready, always ready) writes the atlas size
//   and letter spacing; write it only while the block is idle.
//   A found glyph is worked in two serial texcoord divisions (18 quotient
//   bits each, one bit a cycle, u and v in parallel) followed by six vertex
//   outputs; a missing glyph skips the divisions. Layout items are handled
//   one at a time by the back end, which takes the next one only after the
//   last vertex of the previous one has been emitted; a two-entry queue lets
//   loads and lookups go ahead.
//   When the receiver stalls, the output register holds its vertex and the
//   queue fills, after which in_stall rises.
//   Reset clears the glyph table valid bits and the pen, and sets the atlas
//   to 256 x 256 with a spacing of 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "glyph_quad_text_layout_defines.svh"

module glyph_quad_text_layout import gqtl_pkg::*;
#(
    parameter int GLYPH_CODES  = 256,
    parameter int TEX_SIZE_MAX = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIZE_W = $clog2(TEX_SIZE_MAX + 1);
    localparam logic [CFG_DATA_W-1:0] SIZE_LIMIT = CFG_DATA_W'(TEX_SIZE_MAX);

    logic [CFG_DATA_W-1:0] tex_width_reg, tex_height_reg;
    logic [SPACING_W-1:0]  spacing_reg;
    logic [SIZE_W-1:0]     size_u, size_v;

    queue_push_t           q_push;
    job_t                  q_head;
    logic                  q_head_valid, q_pop;
    logic [QCNT_W-1:0]     q_count;
    logic                  cfg_write;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= TEX_SIZE_RESET;
            tex_height_reg <= TEX_SIZE_RESET;
            spacing_reg    <= SPACING_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:      tex_width_reg  <= cfg_data;
                CFG_TEX_HEIGHT:     tex_height_reg <= cfg_data;
                CFG_LETTER_SPACING: spacing_reg    <= cfg_data[SPACING_W-1:0];
                default:            spacing_reg    <= spacing_reg;
            endcase
        end
    end

    // Atlas sizes clamped to 1..TEX_SIZE_MAX
    assign size_u = (tex_width_reg == '0) ? SIZE_W'(1) :
                    (tex_width_reg > SIZE_LIMIT) ? SIZE_W'(TEX_SIZE_MAX) :
                    tex_width_reg[SIZE_W-1:0];
    assign size_v = (tex_height_reg == '0) ? SIZE_W'(1) :
                    (tex_height_reg > SIZE_LIMIT) ? SIZE_W'(TEX_SIZE_MAX) :
                    tex_height_reg[SIZE_W-1:0];

    gqtl_front #(.GLYPH_CODES(GLYPH_CODES)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (q_push),
        .q_count  (q_count)
    );

    gqtl_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .count      (q_count)
    );

    gqtl_back #(.SIZE_W(SIZE_W)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .size_u     (size_u),
        .size_v     (size_v),
        .spacing    (spacing_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // Queue bookkeeping checks
    `GQTL_ASSERT_IMPLY(a_push_room, clk, rst_n, q_push.valid, q_count < QCNT_W'(QUEUE_DEPTH), "job queue pushed while full")
    `GQTL_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, q_pop, q_count != '0, "job queue popped while empty")
    `GQTL_ASSERT_NEXT(a_count_up, clk, rst_n, q_push.valid && !q_pop, q_count == $past(q_count) + 1'b1, "job queue count did not grow on push")
    `GQTL_ASSERT_IMPLY(a_full_stalls, clk, rst_n, q_count == QCNT_W'(QUEUE_DEPTH), in_stall, "input taken while job queue full")

endmodule

`default_nettype wire
